>>> hdl/ema_pkg.sv
// Shared types and constants for the energy meter accumulator.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package ema_pkg;

	localparam int PORTS       = 2;
	localparam int PORT_W      = 1;
	localparam int ENERGY_BITS = 48;
	localparam int TICK_W      = 32;
	localparam int CFG_W       = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int COUNT_W     = 8;
	localparam int OUT_DEPTH   = 8;
	localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

	localparam logic [CFG_W-1:0]   RST_CALC_PERIOD = 32'd1000;
	localparam logic [CFG_W-1:0]   RST_SAVE_PERIOD = 32'd60000;
	localparam logic [CFG_W-1:0]   RST_ABNORMAL    = 32'd10000;
	localparam logic [CFG_W-1:0]   RST_IMM_SAVE    = 32'd1000;
	localparam logic [CFG_W-1:0]   RST_MIN_SAVE    = 32'd10;
	localparam logic [COUNT_W-1:0] RST_TRY_LIMIT   = 8'd3;

	typedef logic [ENERGY_BITS-1:0] energy_t;
	typedef logic [PORT_W-1:0]      port_t;
	typedef logic [TICK_W-1:0]      tick_t;
	typedef logic [COUNT_W-1:0]     count_t;

	typedef enum logic {
		FUNC_STEP = 1'b0,
		FUNC_LOAD = 1'b1
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CALC_PERIOD = 3'd0,
		REG_SAVE_PERIOD = 3'd1,
		REG_ABNORMAL    = 3'd2,
		REG_IMM_SAVE    = 3'd3,
		REG_MIN_SAVE    = 3'd4,
		REG_TRY_LIMIT   = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		func_t   func;
		port_t   port;
		tick_t   now_ms;
		logic    meter_ready;
		energy_t meter_reading;
		logic    pilot_at_12v;
		energy_t stored_energy;
		logic    load_ok;
	} item_t;

	typedef struct packed {
		port_t   result_port;
		logic    save_request;
		energy_t total_energy;
		logic    error_raised;
		logic    error_cleared;
		logic    error_active;
	} result_t;

	typedef struct packed {
		energy_t prev_reading;
		energy_t saved_total;
		energy_t running_total;
		count_t  err_count;
		logic    err_flag;
		tick_t   calc_stamp;
		tick_t   save_stamp;
	} state_t;

endpackage

`default_nettype wire

>>> hdl/ema_channels.sv
// Valid/ready channel interfaces for items in and results out.
// Depends on ema_pkg for field widths.
`default_nettype none

interface ema_item_if;
	logic                 valid;
	logic                 ready;
	logic                 func;
	ema_pkg::port_t       port;
	ema_pkg::tick_t       now_ms;
	logic                 meter_ready;
	ema_pkg::energy_t     meter_reading;
	logic                 pilot_at_12v;
	ema_pkg::energy_t     stored_energy;
	logic                 load_ok;

	modport source (
		output valid, func, port, now_ms, meter_ready, meter_reading,
		       pilot_at_12v, stored_energy, load_ok,
		input  ready
	);
	modport sink (
		input  valid, func, port, now_ms, meter_ready, meter_reading,
		       pilot_at_12v, stored_energy, load_ok,
		output ready
	);
endinterface

interface ema_result_if;
	logic                 valid;
	logic                 ready;
	ema_pkg::port_t       result_port;
	logic                 save_request;
	ema_pkg::energy_t     total_energy;
	logic                 error_raised;
	logic                 error_cleared;
	logic                 error_active;

	modport source (
		output valid, result_port, save_request, total_energy,
		       error_raised, error_cleared, error_active,
		input  ready
	);
	modport sink (
		input  valid, result_port, save_request, total_energy,
		       error_raised, error_cleared, error_active,
		output ready
	);
endinterface

`default_nettype wire

>>> hdl/ema_fifo.sv
// Result queue between the accumulator pipeline and the output channel.
// Depends on ema_pkg (result_t, OUT_DEPTH).
`default_nettype none

module ema_fifo (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	input  wire ema_pkg::result_t             push_data,
	input  wire logic                         pop,
	output ema_pkg::result_t                  head_data,
	output logic                              head_valid,
	output logic [ema_pkg::OUT_CNT_W-1:0]     level
);

	ema_pkg::result_t                  slot_mem [ema_pkg::OUT_DEPTH];
	logic [ema_pkg::OUT_PTR_W-1:0]     wr_ptr_q;
	logic [ema_pkg::OUT_PTR_W-1:0]     rd_ptr_q;
	logic [ema_pkg::OUT_CNT_W-1:0]     level_q;

	function automatic logic [ema_pkg::OUT_PTR_W-1:0] ptr_inc(
		logic [ema_pkg::OUT_PTR_W-1:0] p);
		return (p == ema_pkg::OUT_PTR_W'(ema_pkg::OUT_DEPTH - 1)) ?
		       '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
			case ({push, pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_mem[wr_ptr_q] <= push_data;
	end

	assign head_data  = slot_mem[rd_ptr_q];
	assign head_valid = (level_q != '0);
	assign level      = level_q;

endmodule

`default_nettype wire

>>> hdl/energy_meter_accumulator.sv
// Per-port charger energy accumulator: three-stage read-modify-write over a port state memory.
// Depends on ema_pkg, ema_channels (ema_item_if, ema_result_if) and ema_fifo.
//
// One item is taken per clock. The port state sits in a PORTS-entry memory read on the
// transfer edge; stage 1 checks the calculation period and forms the reading increase, stage 2
// updates the saturating running total, stage 3 makes the save and fault decisions and writes
// the entry back. Items for the same port may follow each other in consecutive cycles: each
// field is forwarded from the stage or write-back register holding its newest value. A result
// is pushed from stage 3 into an 8-entry queue and offered from there; the input drops
// ready only when eight items are outstanding. Entries read as zero until first written, so
// there is no clearing pass after reset. Configuration writes take effect on the next item.
`default_nettype none

module energy_meter_accumulator (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	ema_item_if.sink                               item,
	ema_result_if.source                           result,
	input  wire logic                              cfg_wr_en,
	input  wire logic [ema_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ema_pkg::CFG_W-1:0]         cfg_wdata
);

	localparam int EB = ema_pkg::ENERGY_BITS;

	// configuration
	logic [ema_pkg::CFG_W-1:0] calc_period_q;
	logic [ema_pkg::CFG_W-1:0] save_period_q;
	logic [ema_pkg::CFG_W-1:0] abnormal_q;
	logic [ema_pkg::CFG_W-1:0] imm_save_q;
	logic [ema_pkg::CFG_W-1:0] min_save_q;
	ema_pkg::count_t           try_limit_q;

	// channels and bookkeeping
	ema_pkg::item_t                    in_item;
	logic                              in_xfer;
	logic                              out_xfer;
	logic [ema_pkg::OUT_CNT_W-1:0]     cnt_q;
	logic [ema_pkg::OUT_CNT_W-1:0]     fifo_level;
	ema_pkg::result_t                  head_res;

	// state memory
	ema_pkg::state_t                   state_mem [ema_pkg::PORTS];
	logic [ema_pkg::PORTS-1:0]         ent_vld_q;
	ema_pkg::state_t                   state_rd_q;
	logic                              rd_vld_q;

	// pipeline
	logic             v_s1, v_s2, v_s3;
	ema_pkg::item_t   item_s1, item_s2, item_s3;
	ema_pkg::state_t  st_s2, st_s3;
	logic             calc_s2, calc_s3;
	ema_pkg::energy_t inc_s2;

	ema_pkg::state_t  st_b1, st_n1, st_b2, st_n2, st_b3, st_n3;
	logic             calc_s1;
	ema_pkg::energy_t inc_s1;
	logic [EB:0]      sum_s2;
	ema_pkg::energy_t delta_s3;
	logic             gt_s3, abn_s3, save_s3, raised_s3, cleared_s3;
	ema_pkg::result_t res_s3;

	// write-back register
	logic             wb_v_q;
	ema_pkg::port_t   wb_port_q;
	ema_pkg::state_t  wb_st_q;

	function automatic logic elapsed(ema_pkg::tick_t now, ema_pkg::tick_t stamp,
	                                 logic [ema_pkg::CFG_W-1:0] period);
		ema_pkg::tick_t gap;
		gap = now - stamp;
		return gap >= period;
	endfunction

	function automatic logic port_ok(ema_pkg::port_t p);
		return 32'(p) < ema_pkg::PORTS;
	endfunction

	assign in_item = '{
		func:          ema_pkg::func_t'(item.func),
		port:          item.port,
		now_ms:        item.now_ms,
		meter_ready:   item.meter_ready,
		meter_reading: item.meter_reading,
		pilot_at_12v:  item.pilot_at_12v,
		stored_energy: item.stored_energy,
		load_ok:       item.load_ok
	};

	assign item.ready = (cnt_q < ema_pkg::OUT_CNT_W'(ema_pkg::OUT_DEPTH));
	assign in_xfer    = item.valid && item.ready;
	assign out_xfer   = result.valid && result.ready;

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calc_period_q <= ema_pkg::RST_CALC_PERIOD;
			save_period_q <= ema_pkg::RST_SAVE_PERIOD;
			abnormal_q    <= ema_pkg::RST_ABNORMAL;
			imm_save_q    <= ema_pkg::RST_IMM_SAVE;
			min_save_q    <= ema_pkg::RST_MIN_SAVE;
			try_limit_q   <= ema_pkg::RST_TRY_LIMIT;
		end else if (cfg_wr_en) begin
			case (ema_pkg::cfg_idx_t'(cfg_index))
				ema_pkg::REG_CALC_PERIOD: calc_period_q <= cfg_wdata;
				ema_pkg::REG_SAVE_PERIOD: save_period_q <= cfg_wdata;
				ema_pkg::REG_ABNORMAL:    abnormal_q    <= cfg_wdata;
				ema_pkg::REG_IMM_SAVE:    imm_save_q    <= cfg_wdata;
				ema_pkg::REG_MIN_SAVE:    min_save_q    <= cfg_wdata;
				ema_pkg::REG_TRY_LIMIT:   try_limit_q   <= cfg_wdata[ema_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1: period check and reading increase
	always_comb begin
		st_b1 = rd_vld_q ? state_rd_q : '0;
		if (wb_v_q && wb_port_q == item_s1.port)
			st_b1 = wb_st_q;
		if (v_s3 && port_ok(item_s3.port) && item_s3.port == item_s1.port) begin
			st_b1.prev_reading = st_s3.prev_reading;
			st_b1.calc_stamp   = st_s3.calc_stamp;
		end
		if (v_s2 && port_ok(item_s2.port) && item_s2.port == item_s1.port) begin
			st_b1.prev_reading = st_s2.prev_reading;
			st_b1.calc_stamp   = st_s2.calc_stamp;
		end
		calc_s1 = port_ok(item_s1.port) && item_s1.func == ema_pkg::FUNC_STEP &&
		          item_s1.meter_ready &&
		          elapsed(item_s1.now_ms, st_b1.calc_stamp, calc_period_q);
		inc_s1 = '0;
		st_n1  = st_b1;
		if (calc_s1) begin
			if (item_s1.meter_reading > st_b1.prev_reading)
				inc_s1 = item_s1.meter_reading - st_b1.prev_reading;
			st_n1.prev_reading = item_s1.meter_reading;
			st_n1.calc_stamp   = item_s1.now_ms;
		end
	end

	// stage 2: running total, saturating on steps, set on loads
	always_comb begin
		st_b2 = st_s2;
		if (wb_v_q && wb_port_q == item_s2.port) begin
			st_b2.running_total = wb_st_q.running_total;
			st_b2.saved_total   = wb_st_q.saved_total;
			st_b2.save_stamp    = wb_st_q.save_stamp;
			st_b2.err_count     = wb_st_q.err_count;
			st_b2.err_flag      = wb_st_q.err_flag;
		end
		if (v_s3 && port_ok(item_s3.port) && item_s3.port == item_s2.port)
			st_b2.running_total = st_s3.running_total;
		sum_s2 = {1'b0, st_b2.running_total} + {1'b0, inc_s2};
		st_n2  = st_b2;
		if (item_s2.func == ema_pkg::FUNC_LOAD)
			st_n2.running_total = item_s2.load_ok ? item_s2.stored_energy : '0;
		else if (calc_s2)
			st_n2.running_total = sum_s2[EB] ? '1 : sum_s2[EB-1:0];
	end

	// stage 3: save and fault decisions
	always_comb begin
		st_b3 = st_s3;
		if (wb_v_q && wb_port_q == item_s3.port) begin
			st_b3.saved_total = wb_st_q.saved_total;
			st_b3.save_stamp  = wb_st_q.save_stamp;
			st_b3.err_count   = wb_st_q.err_count;
			st_b3.err_flag    = wb_st_q.err_flag;
		end
		gt_s3    = st_b3.running_total > st_b3.saved_total;
		delta_s3 = st_b3.running_total - st_b3.saved_total;
		abn_s3   = delta_s3 > EB'(abnormal_q);
		save_s3  = 1'b0;
		raised_s3  = 1'b0;
		cleared_s3 = 1'b0;
		st_n3    = st_b3;
		if (item_s3.func == ema_pkg::FUNC_LOAD) begin
			st_n3.saved_total = st_b3.running_total;
		end else begin
			if (calc_s3 && gt_s3) begin
				if (abn_s3) begin
					if (st_b3.err_count != '1)
						st_n3.err_count = st_b3.err_count + 1'b1;
				end else begin
					save_s3 = (delta_s3 > EB'(imm_save_q)) ||
					          (elapsed(item_s3.now_ms, st_b3.save_stamp, save_period_q) &&
					           delta_s3 >= EB'(min_save_q));
					if (save_s3) begin
						st_n3.save_stamp  = item_s3.now_ms;
						st_n3.saved_total = st_b3.running_total;
					end
				end
			end
			if (!item_s3.pilot_at_12v) begin
				if (!st_b3.err_flag && st_n3.err_count > try_limit_q) begin
					st_n3.err_flag = 1'b1;
					raised_s3      = 1'b1;
				end
			end else if (st_b3.err_flag) begin
				st_n3.err_flag  = 1'b0;
				st_n3.err_count = '0;
				cleared_s3      = 1'b1;
			end
		end
		res_s3             = '0;
		res_s3.result_port = item_s3.port;
		if (port_ok(item_s3.port)) begin
			res_s3.save_request  = save_s3;
			res_s3.total_energy  = st_n3.running_total;
			res_s3.error_raised  = raised_s3;
			res_s3.error_cleared = cleared_s3;
			res_s3.error_active  = st_n3.err_flag;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			wb_v_q    <= 1'b0;
			ent_vld_q <= '0;
			rd_vld_q  <= 1'b0;
			cnt_q     <= '0;
		end else begin
			v_s1     <= in_xfer;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			wb_v_q   <= v_s3 && port_ok(item_s3.port);
			rd_vld_q <= ent_vld_q[item.port];
			if (v_s3 && port_ok(item_s3.port))
				ent_vld_q[item_s3.port] <= 1'b1;
			case ({in_xfer, out_xfer})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// payload and memory
	always_ff @(posedge clk) begin
		state_rd_q <= state_mem[item.port];
		if (v_s3 && port_ok(item_s3.port))
			state_mem[item_s3.port] <= st_n3;
		item_s1   <= in_item;
		item_s2   <= item_s1;
		st_s2     <= st_n1;
		calc_s2   <= calc_s1;
		inc_s2    <= inc_s1;
		item_s3   <= item_s2;
		st_s3     <= st_n2;
		calc_s3   <= calc_s2;
		wb_port_q <= item_s3.port;
		wb_st_q   <= st_n3;
	end

	ema_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (v_s3),
		.push_data  (res_s3),
		.pop        (out_xfer),
		.head_data  (head_res),
		.head_valid (result.valid),
		.level      (fifo_level)
	);

	assign result.result_port   = head_res.result_port;
	assign result.save_request  = head_res.save_request;
	assign result.total_energy  = head_res.total_energy;
	assign result.error_raised  = head_res.error_raised;
	assign result.error_cleared = head_res.error_cleared;
	assign result.error_active  = head_res.error_active;

	// outstanding items are exactly those in flight plus those queued
	a_cnt_matches: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == ema_pkg::OUT_CNT_W'(v_s1) + ema_pkg::OUT_CNT_W'(v_s2) +
		         ema_pkg::OUT_CNT_W'(v_s3) + fifo_level)
		else $error("outstanding count out of step with pipeline and queue");

	a_raise_clear_excl: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> !(res_s3.error_raised && res_s3.error_cleared))
		else $error("fault raised and cleared in one transfer");

	a_raise_written: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && res_s3.error_raised) |=> (wb_v_q && wb_st_q.err_flag))
		else $error("raised fault not written back");

endmodule

`default_nettype wire

>>> sim/tb_energy_meter_accumulator.sv
// Self-checking testbench for energy_meter_accumulator: a directed table, then random phases.
// Depends on ema_pkg, ema_channels and the block; results are checked against typed rows or a predictor.
`timescale 1ns / 1ps

module tb_energy_meter_accumulator;

	localparam int               STALL_LIMIT = 2000;
	localparam int               PHASES      = 6;
	localparam ema_pkg::energy_t E_MAX       = '1;
	localparam ema_pkg::tick_t   T_MAX       = '1;
	localparam ema_pkg::result_t NO_WANT     = '0;
	localparam ema_pkg::func_t   STEP        = ema_pkg::FUNC_STEP;
	localparam ema_pkg::func_t   LOAD        = ema_pkg::FUNC_LOAD;

	typedef struct packed {
		ema_pkg::item_t   it;
		logic             typed;
		ema_pkg::result_t want;
	} drow_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_wr_en;
	logic [ema_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ema_pkg::CFG_W-1:0]     cfg_wdata;

	ema_item_if   item_ch ();
	ema_result_if result_ch ();

	energy_meter_accumulator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// predictor state and configuration copy
	ema_pkg::energy_t prev_rd   [ema_pkg::PORTS];
	ema_pkg::energy_t saved_tot [ema_pkg::PORTS];
	ema_pkg::energy_t run_tot   [ema_pkg::PORTS];
	ema_pkg::count_t  err_cnt   [ema_pkg::PORTS];
	logic             err_flg   [ema_pkg::PORTS];
	ema_pkg::tick_t   calc_ts   [ema_pkg::PORTS];
	ema_pkg::tick_t   save_ts   [ema_pkg::PORTS];
	ema_pkg::tick_t   cfg_calc     = ema_pkg::RST_CALC_PERIOD;
	ema_pkg::tick_t   cfg_save     = ema_pkg::RST_SAVE_PERIOD;
	ema_pkg::tick_t   cfg_abnormal = ema_pkg::RST_ABNORMAL;
	ema_pkg::tick_t   cfg_imm      = ema_pkg::RST_IMM_SAVE;
	ema_pkg::tick_t   cfg_min      = ema_pkg::RST_MIN_SAVE;
	ema_pkg::count_t  cfg_limit    = ema_pkg::RST_TRY_LIMIT;

	ema_pkg::result_t due_results [$];
	int               mismatches = 0;
	int               items_in   = 0;
	int               burst_left = 0;
	int               quiet      = 0;
	bit               hold_done  = 1'b0;
	ema_pkg::tick_t   gen_now    = '0;
	ema_pkg::energy_t gen_rd [ema_pkg::PORTS];

	drow_t dir_tab [0:21] = '{
		'{'{STEP, 1'b0, 32'd0,     1'b1, 48'd0,     1'b1, 48'd0,     1'b0}, 1'b1,
		  '{1'b0, 1'b0, 48'd0, 1'b0, 1'b0, 1'b0}},
		'{'{LOAD, 1'b0, 32'd0,     1'b0, 48'd0,     1'b0, E_MAX,     1'b1}, 1'b1,
		  '{1'b0, 1'b0, E_MAX, 1'b0, 1'b0, 1'b0}},
		'{'{STEP, 1'b0, 32'd1000,  1'b1, 48'd5,     1'b1, 48'd0,     1'b0}, 1'b1,
		  '{1'b0, 1'b0, E_MAX, 1'b0, 1'b0, 1'b0}},
		'{'{LOAD, 1'b0, 32'd1000,  1'b1, 48'd0,     1'b1, E_MAX,     1'b0}, 1'b1,
		  '{1'b0, 1'b0, 48'd0, 1'b0, 1'b0, 1'b0}},
		'{'{LOAD, 1'b1, 32'd1000,  1'b0, 48'd0,     1'b1, 48'd12345, 1'b1}, 1'b1,
		  '{1'b1, 1'b0, 48'd12345, 1'b0, 1'b0, 1'b0}},
		'{'{STEP, 1'b0, 32'd2000,  1'b1, 48'd20,    1'b1, 48'd0, 1'b0}, 1'b0, NO_WANT},
		'{'{STEP, 1'b0, 32'd2500,  1'b1, 48'd2000,  1'b1, 48'd0, 1'b0}, 1'b0, NO_WANT},
		'{'{STEP, 1'b0, 32'd3000,  1'b1, 48'd1500,  1'b1, 48'd0, 1'b0}, 1'b0, NO_WANT},
		'{'{STEP, 1'b0, 32'd4000,  1'b1, 48'd1000,  1'b1, 48'd0, 1'b0}, 1'b0, NO_WANT},
		'{'{STEP, 1'b0, 32'd5000,  1'b0, 48'd9999,  1'b1, 48'd0, 1'b0}, 1'b0, NO_WANT},
		'{'{STEP, 1'b0, 32'd64000, 1'b1, 48'd1020,  1'b1, 48'd0, 1'b0}, 1'b0, NO_WANT},
		'{'{STEP, 1'b0, 32'd65000, 1'b1, 48'd21020, 1'b1, 48'd0, 1'b0}, 1'b0, NO_WANT},
		'{'{STEP, 1'b0, 32'd66000, 1'b1, 48'd21020, 1'b0, 48'd0, 1'b0}, 1'b0, NO_WANT},
		'{'{STEP, 1'b0, 32'd67000, 1'b1, 48'd21020, 1'b1, 48'd0, 1'b0}, 1'b0, NO_WANT},
		'{'{STEP, 1'b0, 32'd68000, 1'b1, 48'd21020, 1'b1, 48'd0, 1'b0}, 1'b0, NO_WANT},
		'{'{STEP, 1'b0, 32'd69000, 1'b1, 48'd21020, 1'b0, 48'd0, 1'b0}, 1'b0, NO_WANT},
		'{'{STEP, 1'b0, 32'd69100, 1'b1, 48'd21020, 1'b0, 48'd0, 1'b0}, 1'b0, NO_WANT},
		'{'{STEP, 1'b0, 32'd69200, 1'b1, 48'd21020, 1'b1, 48'd0, 1'b0}, 1'b0, NO_WANT},
		'{'{STEP, 1'b0, T_MAX,     1'b1, 48'd21020, 1'b1, 48'd0, 1'b0}, 1'b0, NO_WANT},
		'{'{STEP, 1'b0, 32'd999,   1'b1, 48'd21020, 1'b1, 48'd0, 1'b0}, 1'b0, NO_WANT},
		'{'{STEP, 1'b1, 32'd1000,  1'b1, E_MAX,     1'b0, 48'd0, 1'b0}, 1'b0, NO_WANT},
		'{'{LOAD, 1'b1, T_MAX,     1'b1, E_MAX,     1'b0, 48'd0,     1'b1}, 1'b1,
		  '{1'b1, 1'b0, 48'd0, 1'b0, 1'b0, 1'b0}}
	};

	function automatic ema_pkg::result_t meter_step(ema_pkg::item_t it);
		ema_pkg::result_t              r;
		int                            p;
		logic [ema_pkg::ENERGY_BITS:0] sum;
		ema_pkg::energy_t              delta;
		logic                          save;
		r = '0;
		save = 1'b0;
		p = int'(it.port);
		r.result_port = it.port;
		if (it.func == ema_pkg::FUNC_LOAD) begin
			run_tot[p] = it.load_ok ? it.stored_energy : '0;
			saved_tot[p] = run_tot[p];
		end else begin
			if (it.meter_ready &&
			    ema_pkg::tick_t'(it.now_ms - calc_ts[p]) >= cfg_calc) begin
				calc_ts[p] = it.now_ms;
				if (it.meter_reading > prev_rd[p]) begin
					sum = {1'b0, run_tot[p]} +
					      {1'b0, ema_pkg::energy_t'(it.meter_reading - prev_rd[p])};
					run_tot[p] = sum[ema_pkg::ENERGY_BITS] ? E_MAX :
					             sum[ema_pkg::ENERGY_BITS-1:0];
				end
				prev_rd[p] = it.meter_reading;
				if (run_tot[p] > saved_tot[p]) begin
					delta = run_tot[p] - saved_tot[p];
					if (delta > ema_pkg::energy_t'(cfg_abnormal)) begin
						if (err_cnt[p] != 8'hFF)
							err_cnt[p] = err_cnt[p] + 8'd1;
					end else begin
						save = (delta > ema_pkg::energy_t'(cfg_imm)) ||
						       (ema_pkg::tick_t'(it.now_ms - save_ts[p]) >= cfg_save &&
						        delta >= ema_pkg::energy_t'(cfg_min));
						if (save) begin
							save_ts[p] = it.now_ms;
							saved_tot[p] = run_tot[p];
						end
					end
				end
			end
			if (!it.pilot_at_12v) begin
				if (!err_flg[p] && err_cnt[p] > cfg_limit) begin
					err_flg[p] = 1'b1;
					r.error_raised = 1'b1;
				end
			end else if (err_flg[p]) begin
				err_flg[p] = 1'b0;
				err_cnt[p] = '0;
				r.error_cleared = 1'b1;
			end
		end
		r.save_request = save;
		r.total_energy = run_tot[p];
		r.error_active = err_flg[p];
		return r;
	endfunction

	function automatic ema_pkg::tick_t pick_setting(ema_pkg::tick_t typical);
		ema_pkg::tick_t v;
		case ($urandom_range(0, 7))
			0:       v = '0;
			1:       v = '1;
			7:       v = $urandom;
			default: v = $urandom_range(0, typical);
		endcase
		return v;
	endfunction

	function automatic ema_pkg::item_t rand_item();
		ema_pkg::item_t it;
		int             p;
		it = '0;
		p = $urandom_range(0, ema_pkg::PORTS - 1);
		it.port = ema_pkg::port_t'(p);
		it.func = ($urandom_range(0, 19) == 0) ? ema_pkg::FUNC_LOAD : ema_pkg::FUNC_STEP;
		case ($urandom_range(0, 9))
			0:                ;
			1, 2, 3, 4, 5, 6: gen_now = gen_now + $urandom_range(0, 1500);
			7:                gen_now = gen_now + cfg_calc;
			8:                gen_now = gen_now + $urandom;
			default:          gen_now = $urandom;
		endcase
		it.now_ms = gen_now;
		it.meter_ready = $urandom_range(0, 9) != 0;
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11:
			        gen_rd[p] = gen_rd[p] + $urandom_range(0, 1200);
			12, 13, 14: gen_rd[p] = gen_rd[p] + $urandom_range(0, 30000);
			15, 16: gen_rd[p] = gen_rd[p] - $urandom_range(0, 5000);
			17:     gen_rd[p] = ema_pkg::energy_t'({$urandom, $urandom});
			default: ;
		endcase
		it.meter_reading = gen_rd[p];
		it.pilot_at_12v = $urandom_range(0, 9) < 7;
		it.stored_energy = $urandom_range(0, 1) ?
		                   ema_pkg::energy_t'({$urandom, $urandom}) :
		                   ema_pkg::energy_t'($urandom_range(0, 100000));
		it.load_ok = $urandom_range(0, 3) != 0;
		return it;
	endfunction

	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic offer(ema_pkg::item_t it, logic typed, ema_pkg::result_t want);
		ema_pkg::result_t r;
		item_ch.valid         <= 1'b1;
		item_ch.func          <= it.func;
		item_ch.port          <= it.port;
		item_ch.now_ms        <= it.now_ms;
		item_ch.meter_ready   <= it.meter_ready;
		item_ch.meter_reading <= it.meter_reading;
		item_ch.pilot_at_12v  <= it.pilot_at_12v;
		item_ch.stored_energy <= it.stored_energy;
		item_ch.load_ok       <= it.load_ok;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		r = meter_step(it);
		due_results.push_back(typed ? want : r);
		items_in++;
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(ema_pkg::cfg_idx_t idx, logic [ema_pkg::CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			ema_pkg::REG_CALC_PERIOD: cfg_calc     = val;
			ema_pkg::REG_SAVE_PERIOD: cfg_save     = val;
			ema_pkg::REG_ABNORMAL:    cfg_abnormal = val;
			ema_pkg::REG_IMM_SAVE:    cfg_imm      = val;
			ema_pkg::REG_MIN_SAVE:    cfg_min      = val;
			ema_pkg::REG_TRY_LIMIT:   cfg_limit    = val[ema_pkg::COUNT_W-1:0];
			default:                  ;
		endcase
	endtask

	task automatic apply_config(int ph);
		ema_pkg::tick_t  typ [5] = '{32'd1500, 32'd5000, 32'd20000, 32'd2000, 32'd50};
		ema_pkg::tick_t  v   [5];
		ema_pkg::count_t lim;
		case (ph)
			0: begin
				v = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
				lim = '0;
			end
			1: begin
				v = '{32'd1, T_MAX, T_MAX, T_MAX, T_MAX};
				lim = 8'hFF;
			end
			// abnormal at zero counts on every rise, so the count can reach its ceiling
			2: begin
				v = '{32'd0, pick_setting(typ[1]), 32'd0, pick_setting(typ[3]),
				      pick_setting(typ[4])};
				lim = 8'd254;
			end
			default: begin
				foreach (v[i]) v[i] = pick_setting(typ[i]);
				lim = $urandom_range(0, 1) ? ema_pkg::count_t'($urandom_range(0, 8)) :
				                             ema_pkg::count_t'($urandom_range(0, 255));
			end
		endcase
		write_reg(ema_pkg::REG_CALC_PERIOD, v[0]);
		write_reg(ema_pkg::REG_SAVE_PERIOD, v[1]);
		write_reg(ema_pkg::REG_ABNORMAL,    v[2]);
		write_reg(ema_pkg::REG_IMM_SAVE,    v[3]);
		write_reg(ema_pkg::REG_MIN_SAVE,    v[4]);
		write_reg(ema_pkg::REG_TRY_LIMIT,
		          {{(ema_pkg::CFG_W-ema_pkg::COUNT_W){1'b0}}, lim});
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		int phase_len [PHASES];
		phase_len = '{200, 200, 600, 200, 250, 250};
		for (int p = 0; p < ema_pkg::PORTS; p++) begin
			prev_rd[p] = '0;
			saved_tot[p] = '0;
			run_tot[p] = '0;
			err_cnt[p] = '0;
			err_flg[p] = 1'b0;
			calc_ts[p] = '0;
			save_ts[p] = '0;
			gen_rd[p] = '0;
		end
		arst_n                <= 1'b0;
		cfg_wr_en             <= 1'b0;
		cfg_index             <= ema_pkg::REG_CALC_PERIOD;
		cfg_wdata             <= '0;
		item_ch.valid         <= 1'b0;
		item_ch.func          <= ema_pkg::FUNC_STEP;
		item_ch.port          <= '0;
		item_ch.now_ms        <= '0;
		item_ch.meter_ready   <= 1'b0;
		item_ch.meter_reading <= '0;
		item_ch.pilot_at_12v  <= 1'b0;
		item_ch.stored_energy <= '0;
		item_ch.load_ok       <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i]) begin
			pace();
			offer(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].want);
		end
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			apply_config(ph);
			repeat (phase_len[ph]) begin
				pace();
				offer(rand_item(), 1'b0, NO_WANT);
			end
		end
		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// receiver: random stall pattern, plus one long hold-off to fill the block
	initial begin
		int n;
		result_ch.ready <= 1'b0;
		forever begin
			n = $urandom_range(1, 40);
			if (!hold_done && items_in >= 600) begin
				hold_done = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (150) @(posedge clk);
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: begin
						result_ch.ready <= 1'b1;
						repeat (n) @(posedge clk);
					end
					4, 5, 6, 7: begin
						repeat (n) begin
							result_ch.ready <= 1'($urandom_range(0, 1));
							@(posedge clk);
						end
					end
					default: begin
						result_ch.ready <= 1'b0;
						repeat ($urandom_range(1, 12)) @(posedge clk);
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin : result_check
		ema_pkg::result_t got;
		ema_pkg::result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.result_port   = result_ch.result_port;
			got.save_request  = result_ch.save_request;
			got.total_energy  = result_ch.total_energy;
			got.error_raised  = result_ch.error_raised;
			got.error_cleared = result_ch.error_cleared;
			got.error_active  = result_ch.error_active;
			if (due_results.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: unexpected result transfer, port %0d total %0d",
					         $realtime, got.result_port, got.total_energy);
				mismatches++;
			end else begin
				want = due_results.pop_front();
				if (got.result_port !== want.result_port ||
				    got.save_request !== want.save_request ||
				    got.total_energy !== want.total_energy ||
				    got.error_raised !== want.error_raised ||
				    got.error_cleared !== want.error_cleared ||
				    got.error_active !== want.error_active) begin
					if (mismatches < 10)
						$display({"%0t: mismatch port/save/total/raised/cleared/active",
						          " exp %0d %b %0d %b %b %b got %0d %b %0d %b %b %b"},
						         $realtime, want.result_port, want.save_request,
						         want.total_energy, want.error_raised, want.error_cleared,
						         want.error_active, got.result_port, got.save_request,
						         got.total_energy, got.error_raised, got.error_cleared,
						         got.error_active);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule
